// File: sv/clr_pkg.sv
`default_nettype none
package clr_pkg;
   localparam int MAX_DIM = 4096;
   localparam int CW = 13;
   localparam int PW = 12;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 1'b1;
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // A finished line setup handed from the clipper to the stepper.
   typedef struct packed {
      logic       x_is_major;
      logic       step_down;
      logic [CW-1:0] major_pos;
      logic [CW-1:0] minor_pos;
      logic [CW-1:0] major_end;
      logic [CW-1:0] major_delta;
      logic [CW-1:0] minor_delta;
      logic [7:0] colour;
      logic       active;
   } line_setup_type;

   // One queue entry: either a tick or a line setup (inactive when rejected).
   typedef struct packed {
      logic           is_tick;
      line_setup_type setup;
   } cmd_type;
endpackage
`default_nettype wire

// File: sv/clip_and_rasterize_line_core.sv
`default_nettype none
// Clips a segment to the canvas and then returns one Bresenham pixel per tick
// transfer while a line is active. A start transfer is classified and clipped
// by the front part and produces no pixel; each clip step (up to eight) uses a
// 34-iteration bit-serial divider. Every transfer holds the input until the
// front part has pushed its command. Ticks pass through a two-entry queue to
// the stepper, which delivers each pixel from its output register in the cycle
// after it takes the tick.
// Canvas size writes must happen only while idle.
module clip_and_rasterize_line_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic signed [15:0] req_start_x,
   input  wire logic signed [15:0] req_start_y,
   input  wire logic signed [15:0] req_end_x,
   input  wire logic signed [15:0] req_end_y,
   input  wire logic [7:0]  req_colour,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [11:0]      rsp_pixel_x,
   output logic [11:0]      rsp_pixel_y,
   output logic [7:0]       rsp_pixel_colour,
   output logic             rsp_last_pixel,
   input  wire logic        csr_write,
   input  wire logic [clr_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [12:0] csr_data
);
   import clr_pkg::*;
   logic [12:0] width_ff, height_ff;
   logic        push, full, pop, nempty;
   cmd_type     pcmd, head;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 13'd256; height_ff <= 13'd256;
      end else if (csr_write) begin
         case (csr_index)
            CSR_WIDTH:  width_ff <= csr_data;
            CSR_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   clr_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_kind(req_kind), .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_end_x(req_end_x), .req_end_y(req_end_y), .req_colour(req_colour),
      .width_cfg(width_ff), .height_cfg(height_ff),
      .push(push), .push_cmd(pcmd), .q_full(full)
   );
   clr_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_cmd(pcmd), .full(full),
      .pop(pop), .not_empty(nempty), .head(head)
   );
   clr_back u_back (
      .clock(clock), .reset(reset), .q_valid(nempty), .head(head), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_pixel_x(rsp_pixel_x),
      .rsp_pixel_y(rsp_pixel_y), .rsp_pixel_colour(rsp_pixel_colour),
      .rsp_last_pixel(rsp_last_pixel)
   );
endmodule
`default_nettype wire

// File: sv/clr_div.sv
`default_nettype none
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
module clr_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic signed [33:0] dividend,
   input  wire logic signed [17:0] divisor,
   output logic             done,
   output logic signed [33:0] quotient
);
   logic [33:0] q_ff, q_in;
   logic [33:0] r_ff, r_in;
   logic [17:0] d_ff, d_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [34:0] trial;
   logic [33:0] shr;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      shr = '0; trial = '0;
      if (start) begin
         q_in = dividend[33] ? 34'(-dividend) : dividend;
         d_in = divisor[17] ? 18'(-divisor) : divisor;
         neg_in = dividend[33] ^ divisor[17];
         r_in = '0;
         cnt_in = 6'd34;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         shr = {r_ff[32:0], q_ff[33]};
         trial = {1'b0, shr} - {17'd0, d_ff};
         if (!trial[34]) begin
            r_in = trial[33:0];
            q_in = {q_ff[32:0], 1'b1};
         end else begin
            r_in = shr;
            q_in = {q_ff[32:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quotient = neg_ff ? 34'(-q_ff) : q_ff;
endmodule
`default_nettype wire

// File: sv/clr_front.sv
`default_nettype none
// Accepts items, clips start items with Cohen-Sutherland and pushes commands.
module clr_front (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic signed [15:0] req_start_x,
   input  wire logic signed [15:0] req_start_y,
   input  wire logic signed [15:0] req_end_x,
   input  wire logic signed [15:0] req_end_y,
   input  wire logic [7:0]  req_colour,
   input  wire logic [12:0] width_cfg,
   input  wire logic [12:0] height_cfg,
   output logic             push,
   output clr_pkg::cmd_type push_cmd,
   input  wire logic        q_full
);
   import clr_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_CODE, S_DECIDE, S_DIV, S_SETUP, S_PUSH
   } state_type;

   state_type   state_ff;
   logic signed [17:0] x1_ff, y1_ff, x2_ff, y2_ff;
   logic signed [17:0] xm_ff, ym_ff;
   logic [3:0]  c1_ff, c2_ff;
   logic [3:0]  steps_ff;
   logic        on1_ff;
   logic        vert_ff;
   logic signed [17:0] e_ff, base_ff;
   cmd_type     cmd_ff;
   logic        div_start_ff;
   logic signed [33:0] div_num_ff;
   logic signed [17:0] div_den_ff;
   logic        div_done;
   logic signed [33:0] div_q;

   clr_div u_div (
      .clock(clock), .reset(reset), .start(div_start_ff),
      .dividend(div_num_ff), .divisor(div_den_ff),
      .done(div_done), .quotient(div_q)
   );

   function automatic logic signed [17:0] edge_of(input logic [12:0] r);
      logic [12:0] d;
      d = r;
      if (d < 13'd1) d = 13'd1;
      if (d > 13'(MAX_DIM)) d = 13'(MAX_DIM);
      return 18'(d) - 18'sd1;
   endfunction

   function automatic logic [3:0] ocode(input logic signed [17:0] x, y, xm, ym);
      return {y > ym, y < 0, x > xm, x < 0};
   endfunction

   logic signed [17:0] px, py, qx, qy;
   logic        on1;
   logic [3:0]  cc;
   logic signed [17:0] ee;
   logic        vv;
   logic        reject;
   logic signed [17:0] dx, dy, adx, ady;
   logic signed [17:0] a1, b1, a2, b2;
   logic        xmaj;

   always_comb begin
      // The endpoint that moves is endpoint 1 while it is still outside.
      on1 = (c1_ff != 4'd0);
      px = on1 ? x1_ff : x2_ff; py = on1 ? y1_ff : y2_ff;
      qx = on1 ? x2_ff : x1_ff; qy = on1 ? y2_ff : y1_ff;
      cc = on1 ? c1_ff : c2_ff;
      vv = (cc[1:0] != 2'd0);
      if (vv) ee = cc[0] ? 18'sd0 : xm_ff;
      else ee = cc[2] ? 18'sd0 : ym_ff;
      reject = ((c1_ff & c2_ff) != 4'd0) || (steps_ff >= 4'd8) ||
               (vv && qx == px) || (!vv && qy == py);
      dx = x2_ff - x1_ff; dy = y2_ff - y1_ff;
      adx = dx[17] ? -dx : dx; ady = dy[17] ? -dy : dy;
      xmaj = adx > ady;
      if (xmaj) begin a1 = x1_ff; b1 = y1_ff; a2 = x2_ff; b2 = y2_ff; end
      else begin a1 = y1_ff; b1 = x1_ff; a2 = y2_ff; b2 = x2_ff; end
      if (a1 > a2) begin
         {a1, a2} = {a2, a1};
         {b1, b2} = {b2, b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         div_start_ff <= 1'b0;
      end else begin
         div_start_ff <= (state_ff == S_DECIDE) && ((c1_ff | c2_ff) != 4'd0) && !reject;
         case (state_ff)
            S_IDLE: if (req_valid && !req_stall) begin
               if (req_kind == KIND_TICK) begin
                  cmd_ff.is_tick <= 1'b1;
                  state_ff <= S_PUSH;
               end else begin
                  cmd_ff.is_tick <= 1'b0;
                  cmd_ff.setup.colour <= req_colour;
                  x1_ff <= 18'(req_start_x); y1_ff <= 18'(req_start_y);
                  x2_ff <= 18'(req_end_x); y2_ff <= 18'(req_end_y);
                  xm_ff <= edge_of(width_cfg); ym_ff <= edge_of(height_cfg);
                  steps_ff <= '0;
                  state_ff <= S_CODE;
               end
            end
            S_CODE: begin
               c1_ff <= ocode(x1_ff, y1_ff, xm_ff, ym_ff);
               c2_ff <= ocode(x2_ff, y2_ff, xm_ff, ym_ff);
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               if ((c1_ff | c2_ff) == 4'd0) state_ff <= S_SETUP;
               else if (reject) begin
                  cmd_ff.setup.active <= 1'b0;
                  state_ff <= S_PUSH;
               end else begin
                  steps_ff <= steps_ff + 4'd1;
                  on1_ff <= on1;
                  vert_ff <= vv;
                  e_ff <= ee;
                  base_ff <= vv ? py : px;
                  div_num_ff <= vv ? (qy - py) * (ee - px) : (qx - px) * (ee - py);
                  div_den_ff <= vv ? (qx - px) : (qy - py);
                  state_ff <= S_DIV;
               end
            end
            S_DIV: if (div_done) begin
               if (vert_ff) begin
                  if (on1_ff) begin x1_ff <= e_ff; y1_ff <= base_ff + 18'(div_q); end
                  else begin x2_ff <= e_ff; y2_ff <= base_ff + 18'(div_q); end
               end else begin
                  if (on1_ff) begin y1_ff <= e_ff; x1_ff <= base_ff + 18'(div_q); end
                  else begin y2_ff <= e_ff; x2_ff <= base_ff + 18'(div_q); end
               end
               state_ff <= S_CODE;
            end
            S_SETUP: begin
               cmd_ff.setup.x_is_major <= xmaj;
               cmd_ff.setup.step_down <= !(b1 < b2);
               cmd_ff.setup.major_pos <= a1[12:0];
               cmd_ff.setup.minor_pos <= b1[12:0];
               cmd_ff.setup.major_end <= a2[12:0];
               cmd_ff.setup.major_delta <= 13'(a2 - a1);
               cmd_ff.setup.minor_delta <= (b2 > b1) ? 13'(b2 - b1) : 13'(b1 - b2);
               cmd_ff.setup.active <= 1'b1;
               state_ff <= S_PUSH;
            end
            S_PUSH: if (!q_full) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign push = (state_ff == S_PUSH) && !q_full;
   assign push_cmd = cmd_ff;
endmodule
`default_nettype wire

// File: sv/clr_queue.sv
`default_nettype none
// Two-entry command queue between the clipper and the stepper.
module clr_queue (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire clr_pkg::cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output logic         not_empty,
   output clr_pkg::cmd_type head
);
   import clr_pkg::*;
   cmd_type  mem_ff [2];
   logic     wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) mem_ff[wp_ff] <= push_cmd;
   end

   assign full = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign head = mem_ff[rp_ff];
endmodule
`default_nettype wire

// File: sv/clr_back.sv
`default_nettype none
// Bresenham stepper: one pixel per tick, while a line is active, into an output register.
module clr_back (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_valid,
   input  wire clr_pkg::cmd_type head,
   output logic         pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output logic [11:0]  rsp_pixel_x,
   output logic [11:0]  rsp_pixel_y,
   output logic [7:0]   rsp_pixel_colour,
   output logic         rsp_last_pixel
);
   import clr_pkg::*;
   line_setup_type ln_ff;
   logic signed [13:0] err_ff;
   logic signed [13:0] err_sub;
   logic         last;
   logic         ov_ff;

   assign pop = q_valid && !(ov_ff && rsp_stall);
   assign last = ln_ff.major_pos >= ln_ff.major_end;
   assign err_sub = err_ff - $signed({1'b0, ln_ff.minor_delta});

   always_ff @(posedge clock) begin
      if (reset) begin
         ln_ff.active <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         ov_ff <= (pop && head.is_tick && ln_ff.active) || (ov_ff && rsp_stall);
         if (pop) begin
            if (!head.is_tick) begin
               ln_ff <= head.setup;
               err_ff <= 14'(head.setup.major_delta >> 1);
            end else if (ln_ff.active) begin
               rsp_pixel_x <= ln_ff.x_is_major ? ln_ff.major_pos[11:0] : ln_ff.minor_pos[11:0];
               rsp_pixel_y <= ln_ff.x_is_major ? ln_ff.minor_pos[11:0] : ln_ff.major_pos[11:0];
               rsp_pixel_colour <= ln_ff.colour;
               rsp_last_pixel <= last;
               if (err_sub < 0) begin
                  err_ff <= err_sub + $signed({1'b0, ln_ff.major_delta});
                  ln_ff.minor_pos <= ln_ff.step_down ? ln_ff.minor_pos - 13'd1
                                                     : ln_ff.minor_pos + 13'd1;
               end else err_ff <= err_sub;
               ln_ff.major_pos <= ln_ff.major_pos + 13'd1;
               if (last) ln_ff.active <= 1'b0;
            end
         end
      end
   end

   assign rsp_valid = ov_ff;
endmodule
`default_nettype wire

// File: tb/tb.sv
`default_nettype none
module tb;
   import clr_pkg::*;

   typedef struct {
      logic [11:0] x;
      logic [11:0] y;
      logic [7:0]  colour;
      logic        last;
   } pixel_type;

   localparam int CLIP_SETTLE = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_OFF_CYCLES = 300;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_kind;
   logic signed [15:0] req_start_x, req_start_y, req_end_x, req_end_y;
   logic [7:0]  req_colour;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [11:0] rsp_pixel_x, rsp_pixel_y;
   logic [7:0]  rsp_pixel_colour;
   logic        rsp_last_pixel;
   logic        csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [12:0] csr_data;

   clip_and_rasterize_line_core DUT (.*);

   // Shadow of the block's registers and line stepper.
   logic [12:0] shadow_width, shadow_height;
   longint cur_major, cur_minor, major_stop, err_acc, major_span, minor_span;
   bit step_down, x_major, line_on;
   logic [7:0] line_colour;

   pixel_type pixels_due[$];
   int error_count;
   int send_idle_pct, recv_idle_pct;
   int hold_left;
   int quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
      error_count++;
   endtask

   function automatic longint clip_edge(input logic [12:0] reg_value);
      longint d;
      d = reg_value;
      if (d < 1) d = 1;
      if (d > MAX_DIM) d = MAX_DIM;
      return d - 1;
   endfunction

   function automatic int region_code(input longint x, input longint y,
                                      input longint xm, input longint ym);
      int c;
      c = 0;
      if (x < 0) c |= 1;
      if (x > xm) c |= 2;
      if (y < 0) c |= 4;
      if (y > ym) c |= 8;
      return c;
   endfunction

   // Slides (px,py) along the segment onto the edge named by code c.
   function automatic bit slide_to_edge(inout longint px, inout longint py,
                                        input longint qx, input longint qy,
                                        input int c, input longint xm, input longint ym);
      longint e;
      if (c & 3) begin
         e = (c & 1) ? 0 : xm;
         if (qx == px) return 0;
         py = py + (qy - py) * (e - px) / (qx - px);
         px = e;
      end else begin
         e = (c & 4) ? 0 : ym;
         if (qy == py) return 0;
         px = px + (qx - px) * (e - py) / (qy - py);
         py = e;
      end
      return 1;
   endfunction

   function automatic longint magnitude(input longint v);
      return v < 0 ? -v : v;
   endfunction

   task automatic begin_line(input logic signed [15:0] sx, sy, ex, ey, input logic [7:0] col);
      longint xm, ym, x1, y1, x2, y2, a1, b1, a2, b2, t;
      int c1, c2, steps;
      xm = clip_edge(shadow_width);
      ym = clip_edge(shadow_height);
      x1 = sx; y1 = sy; x2 = ex; y2 = ey;
      c1 = region_code(x1, y1, xm, ym);
      c2 = region_code(x2, y2, xm, ym);
      steps = 0;
      line_on = 0;
      line_colour = col;
      while (c1 | c2) begin
         if ((c1 & c2) || steps >= 8) return;
         steps++;
         if (c1) begin
            if (!slide_to_edge(x1, y1, x2, y2, c1, xm, ym)) return;
            c1 = region_code(x1, y1, xm, ym);
         end else begin
            if (!slide_to_edge(x2, y2, x1, y1, c2, xm, ym)) return;
            c2 = region_code(x2, y2, xm, ym);
         end
      end
      x_major = magnitude(x2 - x1) > magnitude(y2 - y1);
      if (x_major) begin
         a1 = x1; b1 = y1; a2 = x2; b2 = y2;
      end else begin
         a1 = y1; b1 = x1; a2 = y2; b2 = x2;
      end
      if (a1 > a2) begin
         t = a1; a1 = a2; a2 = t;
         t = b1; b1 = b2; b2 = t;
      end
      cur_major = a1;
      cur_minor = b1;
      major_stop = a2;
      major_span = a2 - a1;
      minor_span = magnitude(b2 - b1);
      step_down = !(b1 < b2);
      err_acc = major_span / 2;
      line_on = 1;
   endtask

   task automatic predict_transfer(input logic kind, input logic signed [15:0] sx, sy, ex, ey,
                                   input logic [7:0] col);
      pixel_type p;
      if (kind == KIND_START) begin
         begin_line(sx, sy, ex, ey, col);
         return;
      end
      if (!line_on) return;
      p.x = x_major ? cur_major[11:0] : cur_minor[11:0];
      p.y = x_major ? cur_minor[11:0] : cur_major[11:0];
      p.colour = line_colour;
      p.last = cur_major >= major_stop;
      pixels_due.push_back(p);
      err_acc -= minor_span;
      if (err_acc < 0) begin
         err_acc += major_span;
         cur_minor += step_down ? -1 : 1;
      end
      cur_major++;
      if (p.last) line_on = 0;
   endtask

   // Offers one item and returns once it has been transferred; valid stays high.
   task automatic send_item(input logic kind, input logic signed [15:0] sx, sy, ex, ey,
                            input logic [7:0] col);
      int gap;
      @(negedge clock);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 3);
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_start_x <= sx;
      req_start_y <= sy;
      req_end_x <= ex;
      req_end_y <= ey;
      req_colour <= col;
      do @(posedge clock); while (req_stall);
      predict_transfer(kind, sx, sy, ex, ey, col);
   endtask

   task automatic send_tick();
      send_item(KIND_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                8'($urandom));
   endtask

   // Drops valid, waits for every pixel, then lets a possible clip finish.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pixels_due.size() != 0) @(posedge clock);
      repeat (CLIP_SETTLE) @(posedge clock);
   endtask

   task automatic write_canvas(input logic [CSR_IDX_W-1:0] idx, input logic [12:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_WIDTH) shadow_width = value;
      else shadow_height = value;
   endtask

   task automatic set_canvas(input logic [12:0] w, input logic [12:0] h);
      settle();
      write_canvas(CSR_WIDTH, w);
      write_canvas(CSR_HEIGHT, h);
   endtask

   task automatic draw(input int sx, sy, ex, ey, input logic [7:0] col, input int ticks);
      send_item(KIND_START, 16'(sx), 16'(sy), 16'(ex), 16'(ey), col);
      repeat (ticks) send_tick();
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_tick();
      draw(10, 10, 10, 10, 8'd255, 2);
      draw(7, 5, 0, 5, 8'd1, 9);
      draw(3, 40, 5, 2, 8'd2, 40);
      draw(0, 0, 20, 20, 8'd3, 21);
      draw(20, 0, 0, 20, 8'd4, 21);
      draw(-32768, -32768, 32767, 32767, 8'd0, 5);
      draw(32767, -32768, -32768, 32767, 8'd128, 5);
      draw(-5, -5, -1, 300, 8'd5, 2);
      draw(-50, 100, 300, 120, 8'd6, 3);
      draw(100, 300, 120, -40, 8'd7, 4);
      set_canvas(13'd0, 13'd1);
      draw(-3, -7, 9, 4, 8'd8, 2);
      draw(0, 0, 0, 0, 8'd9, 1);
      set_canvas(13'h1FFF, 13'd4096);
      draw(4090, 4095, 5000, 4000, 8'd10, 8);
      draw(4095, 4095, 4095, 4095, 8'd11, 1);
      set_canvas(13'd1, 13'h1FFF);
      draw(-100, 10, 100, 12, 8'd12, 2);
   endtask

   task automatic test_backpressure();
      set_canvas(13'd256, 13'd256);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_item(KIND_START, 16'sd0, 16'sd0, 16'sd30, 16'sd9, 8'd77);
      @(negedge clock);
      hold_left = HOLD_OFF_CYCLES;
      repeat (31) send_tick();
      settle();
   endtask

   function automatic logic [15:0] pick_coord(input int span);
      if ($urandom_range(0, 7) == 0) return 16'($urandom);
      return 16'(int'($urandom_range(0, span * 3 / 2 + 4)) - span / 4 - 2);
   endfunction

   task automatic run_random_lines(input int item_budget, input int span);
      int sent, ticks, remaining;
      sent = 0;
      while (sent < item_budget) begin
         send_item(KIND_START, pick_coord(span), pick_coord(span), pick_coord(span),
                   pick_coord(span), 8'($urandom));
         sent++;
         remaining = line_on ? int'(major_stop - cur_major + 1) : 0;
         if (remaining > 40) remaining = 40;
         case ($urandom_range(0, 9))
            0, 1: ticks = remaining > 0 ? $urandom_range(0, remaining - 1) : 0;
            2: ticks = remaining + $urandom_range(1, 2);
            default: ticks = remaining;
         endcase
         repeat (ticks) send_tick();
         sent += ticks;
      end
   endtask

   task automatic test_random(input int s_pct, input int r_pct,
                              input logic [12:0] w1, h1, w2, h2);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      set_canvas(w1, h1);
      run_random_lines(200, (w1 > h1 ? w1 : h1) > 100 ? 100 : (w1 > h1 ? w1 : h1));
      set_canvas(w2, h2);
      run_random_lines(200, (w2 > h2 ? w2 : h2) > 100 ? 100 : (w2 > h2 ? w2 : h2));
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixels_due.size() == 0) begin
            report_mismatch("pixels delivered beyond those expected", 1, 0);
         end else begin
            want = pixels_due.pop_front();
            if (rsp_pixel_x !== want.x) report_mismatch("pixel_x", rsp_pixel_x, want.x);
            if (rsp_pixel_y !== want.y) report_mismatch("pixel_y", rsp_pixel_y, want.y);
            if (rsp_pixel_colour !== want.colour)
               report_mismatch("pixel_colour", rsp_pixel_colour, want.colour);
            if (rsp_last_pixel !== want.last)
               report_mismatch("last_pixel", rsp_last_pixel, want.last);
         end
      end
   end

   // Ends the run when no transfer happens on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      error_count = 0;
      hold_left = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      shadow_width = 13'd256;
      shadow_height = 13'd256;
      line_on = 0;
      line_colour = 8'd0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_START;
      req_start_x = '0;
      req_start_y = '0;
      req_end_x = '0;
      req_end_y = '0;
      req_colour = '0;
      csr_write = 1'b0;
      csr_index = CSR_WIDTH;
      csr_data = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_backpressure();
      test_random(33, 85, 13'd64, 13'd48, 13'd13, 13'd200);
      test_random(85, 33, 13'd1, 13'd4096, 13'd4096, 13'd4096);
      test_random(0, 0, 13'd256, 13'd256, 13'h1FFF, 13'd0);
      settle();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
`default_nettype wire
